// ===== rtl/core/chn_pkg.sv =====
// package: constants, payload types, control word types and microcode table
`timescale 1ns / 1ps

package chn_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int BIN_BITS   = 8;
    localparam int TOTAL_BITS = 24;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int CNT_W      = $clog2(FRAC_BITS + 1);
    localparam int PC_W       = 3;
    localparam int LAST_BIN   = BIN_COUNT - 1;

    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // jump conditions: the step holds until its condition is true
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_IN_VALID = 2'd1;
    localparam logic [1:0] COND_DIV_LAST = 2'd2;
    localparam logic [1:0] COND_OUT_FREE = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] PC_LD_BIN  = 3'd1;
    localparam logic [PC_W-1:0] PC_DIV_BIN = 3'd2;
    localparam logic [PC_W-1:0] PC_LD_CUM  = 3'd3;
    localparam logic [PC_W-1:0] PC_DIV_CUM = 3'd4;
    localparam logic [PC_W-1:0] PC_EMIT    = 3'd5;

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin_index;
        logic [COUNT_BITS-1:0] count_red;
        logic [COUNT_BITS-1:0] count_green;
        logic [COUNT_BITS-1:0] count_blue;
    } in_item_t;

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin_out;
        logic [COUNT_BITS-1:0] cum_red;
        logic [COUNT_BITS-1:0] cum_green;
        logic [COUNT_BITS-1:0] cum_blue;
        logic [FRAC_W-1:0]     frac_red;
        logic [FRAC_W-1:0]     frac_green;
        logic [FRAC_W-1:0]     frac_blue;
        logic [FRAC_W-1:0]     cum_frac_red;
        logic [FRAC_W-1:0]     cum_frac_green;
        logic [FRAC_W-1:0]     cum_frac_blue;
        logic                  last_bin;
    } out_item_t;

    typedef struct packed {
        logic [1:0]      cond;
        logic [PC_W-1:0] next_pc;
        logic            accept;
        logic            div_load;
        logic            sel_cum;
        logic            div_step;
        logic            store_frac;
        logic            emit;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic sel_cum;
        logic div_step;
        logic store_frac;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctl_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            PC_IDLE:
            begin
                w.cond    = COND_IN_VALID;
                w.next_pc = PC_LD_BIN;
                w.accept  = 1'b1;
            end
            PC_LD_BIN:
            begin
                w.cond     = COND_ALWAYS;
                w.next_pc  = PC_DIV_BIN;
                w.div_load = 1'b1;
            end
            PC_DIV_BIN:
            begin
                w.cond     = COND_DIV_LAST;
                w.next_pc  = PC_LD_CUM;
                w.div_step = 1'b1;
            end
            PC_LD_CUM:
            begin
                w.cond       = COND_ALWAYS;
                w.next_pc    = PC_DIV_CUM;
                w.div_load   = 1'b1;
                w.sel_cum    = 1'b1;
                w.store_frac = 1'b1;
            end
            PC_DIV_CUM:
            begin
                w.cond     = COND_DIV_LAST;
                w.next_pc  = PC_EMIT;
                w.div_step = 1'b1;
            end
            PC_EMIT:
            begin
                w.cond    = COND_OUT_FREE;
                w.next_pc = PC_IDLE;
                w.emit    = 1'b1;
            end
            default:
            begin
                w.cond    = COND_ALWAYS;
                w.next_pc = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/chn_sequencer.sv =====
// microcode sequencer: program counter, division step counter and jump logic
`timescale 1ns / 1ps

module chn_sequencer
    import chn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output ctl_t ctl
);

    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    ucode_t           word;
    logic             go;

    assign word = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:   go = 1'b1;
            COND_IN_VALID: go = sts.in_valid;
            COND_DIV_LAST: go = (cnt_reg == CNT_W'(1));
            COND_OUT_FREE: go = sts.out_free;
            default:       go = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = go ? word.next_pc : pc_reg;
        priority if (word.div_load)
            cnt_next = CNT_W'(FRAC_BITS);
        else if (word.div_step)
            cnt_next = cnt_reg - CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctl.accept     = word.accept;
    assign ctl.div_load   = word.div_load;
    assign ctl.sel_cum    = word.sel_cum;
    assign ctl.div_step   = word.div_step;
    assign ctl.store_frac = word.store_frac;
    assign ctl.emit       = word.emit & go;

endmodule

// ===== rtl/core/chn_div_lane.sv =====
// one divider lane: restoring division of count by total, one quotient bit a cycle
`timescale 1ns / 1ps

module chn_div_lane
    import chn_pkg::*;
(
    input  logic                  clk,
    input  lane_ctl_t             ctl,
    input  logic [COUNT_BITS-1:0] dividend,
    input  logic [TOTAL_BITS-1:0] divisor,
    output logic [FRAC_W-1:0]     quotient
);

    localparam int REM_W = (COUNT_BITS > TOTAL_BITS ? COUNT_BITS : TOTAL_BITS) + 1;

    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [FRAC_BITS-1:0] quo_next;
    logic                 sat_reg;
    logic                 sat_next;
    logic                 zero_reg;
    logic                 zero_next;
    logic [REM_W-1:0]     shifted;
    logic [REM_W-1:0]     div_ext;
    logic                 fits;

    assign div_ext = REM_W'(divisor);
    assign shifted = {rem_reg[REM_W-2:0], 1'b0};
    assign fits    = (shifted >= div_ext);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        zero_next = zero_reg;
        priority if (ctl.load)
        begin
            rem_next  = REM_W'(dividend);
            quo_next  = '0;
            zero_next = (divisor == '0);
            sat_next  = (REM_W'(dividend) >= div_ext);
        end
        else if (ctl.step)
        begin
            rem_next = fits ? (shifted - div_ext) : shifted;
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        sat_reg  <= sat_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        priority if (zero_reg)
            quotient = '0;
        else if (sat_reg)
            quotient = FRAC_ONE;
        else
            quotient = {1'b0, quo_reg};
    end

endmodule

// ===== rtl/core/cumulative_histogram_normalizer.sv =====
// top level: running sums, three divider lanes, sequencer and output register
`timescale 1ns / 1ps

// One histogram bin is taken per transfer and gives one result transfer. An item goes
// through these steps: the bin is taken, then two division passes of one load and
// FRAC_BITS restoring steps each, the bin counts first and the cumulative counts
// second, all three colours at once in three lanes, then the result moves into the
// output register once that register is free or being taken. The next bin is taken
// while a finished result still waits in the output register. pixel_total is written
// through the cfg port, which is always ready, and must only be written while no bin
// is in flight.
module cumulative_histogram_normalizer
    import chn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  bin_valid,
    output logic                  bin_stall,
    input  in_item_t              bin_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_item_t             res_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TOTAL_BITS-1:0] cfg_data
);

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    ctl_t                  ctl;
    sts_t                  sts;
    lane_ctl_t             lane_ctl;
    logic                  accept;

    logic [TOTAL_BITS-1:0] total_reg;
    in_item_t              item_reg;
    logic [COUNT_BITS-1:0] run_red_reg;
    logic [COUNT_BITS-1:0] run_green_reg;
    logic [COUNT_BITS-1:0] run_blue_reg;
    logic [COUNT_BITS-1:0] run_red_next;
    logic [COUNT_BITS-1:0] run_green_next;
    logic [COUNT_BITS-1:0] run_blue_next;
    logic [FRAC_W-1:0]     frac_red_reg;
    logic [FRAC_W-1:0]     frac_green_reg;
    logic [FRAC_W-1:0]     frac_blue_reg;
    logic [FRAC_W-1:0]     q_red;
    logic [FRAC_W-1:0]     q_green;
    logic [FRAC_W-1:0]     q_blue;
    logic [COUNT_BITS-1:0] dvd_red;
    logic [COUNT_BITS-1:0] dvd_green;
    logic [COUNT_BITS-1:0] dvd_blue;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    out_item_t             res_item_reg;
    out_item_t             res_item_next;

    assign cfg_ready = 1'b1;
    assign bin_stall = ~ctl.accept;
    assign accept    = bin_valid & ctl.accept;

    assign sts.in_valid = bin_valid;
    assign sts.out_free = ~res_valid_reg | ~res_stall;

    chn_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    assign lane_ctl.load = ctl.div_load;
    assign lane_ctl.step = ctl.div_step;

    assign dvd_red   = ctl.sel_cum ? run_red_reg   : item_reg.count_red;
    assign dvd_green = ctl.sel_cum ? run_green_reg : item_reg.count_green;
    assign dvd_blue  = ctl.sel_cum ? run_blue_reg  : item_reg.count_blue;

    chn_div_lane u_lane_red (
        .clk      (clk),
        .ctl      (lane_ctl),
        .dividend (dvd_red),
        .divisor  (total_reg),
        .quotient (q_red)
    );

    chn_div_lane u_lane_green (
        .clk      (clk),
        .ctl      (lane_ctl),
        .dividend (dvd_green),
        .divisor  (total_reg),
        .quotient (q_green)
    );

    chn_div_lane u_lane_blue (
        .clk      (clk),
        .ctl      (lane_ctl),
        .dividend (dvd_blue),
        .divisor  (total_reg),
        .quotient (q_blue)
    );

    // bin zero restarts the sums
    always_comb
    begin
        if (bin_item.bin_index == '0)
        begin
            run_red_next   = bin_item.count_red;
            run_green_next = bin_item.count_green;
            run_blue_next  = bin_item.count_blue;
        end
        else
        begin
            run_red_next   = sat_add(run_red_reg, bin_item.count_red);
            run_green_next = sat_add(run_green_reg, bin_item.count_green);
            run_blue_next  = sat_add(run_blue_reg, bin_item.count_blue);
        end
    end

    always_comb
    begin
        res_item_next.bin_out        = item_reg.bin_index;
        res_item_next.cum_red        = run_red_reg;
        res_item_next.cum_green      = run_green_reg;
        res_item_next.cum_blue       = run_blue_reg;
        res_item_next.frac_red       = frac_red_reg;
        res_item_next.frac_green     = frac_green_reg;
        res_item_next.frac_blue      = frac_blue_reg;
        res_item_next.cum_frac_red   = q_red;
        res_item_next.cum_frac_green = q_green;
        res_item_next.cum_frac_blue  = q_blue;
        res_item_next.last_bin       = (32'(item_reg.bin_index) == 32'(LAST_BIN));
    end

    always_comb
    begin
        priority if (ctl.emit)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_BITS'(1);
            run_red_reg   <= '0;
            run_green_reg <= '0;
            run_blue_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_valid)
            begin
                total_reg <= cfg_data;
            end
            if (accept)
            begin
                run_red_reg   <= run_red_next;
                run_green_reg <= run_green_next;
                run_blue_reg  <= run_blue_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= bin_item;
        end
        if (ctl.store_frac)
        begin
            frac_red_reg   <= q_red;
            frac_green_reg <= q_green;
            frac_blue_reg  <= q_blue;
        end
        if (ctl.emit)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

// ===== rtl/core/chn_checker.sv =====
// port checker for the top level and its bind
`timescale 1ns / 1ps

module chn_checker
    import chn_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      bin_valid,
    input logic      bin_stall,
    input logic      res_valid,
    input logic      res_stall,
    input out_item_t res_item
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("stalled result changed");

    // one bin in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_stall |=> bin_stall)
        else $error("bin taken while previous still in work");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.frac_red <= FRAC_ONE && res_item.frac_green <= FRAC_ONE
            && res_item.frac_blue <= FRAC_ONE && res_item.cum_frac_red <= FRAC_ONE
            && res_item.cum_frac_green <= FRAC_ONE && res_item.cum_frac_blue <= FRAC_ONE)
        else $error("fraction above one");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.last_bin == (32'(res_item.bin_out) == 32'(LAST_BIN)))
        else $error("last bin flag wrong");

endmodule

bind cumulative_histogram_normalizer chn_checker u_chk (.*);
